// ===== rtl/core/bmhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic              mode;
      logic [DATA_W-1:0] entry_data;
      logic [PRIO_W-1:0] entry_priority;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   front_data;
      logic [PRIO_W-1:0]   front_priority;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;       // take a new request
      logic rd_parent;    // read parent of pos
      logic up_move;      // write parent into pos, step pos up
      logic rm_load;      // latch removed root and last entry
      logic rd_children;  // read both children of pos
      logic dn_move;      // write larger child into pos, step pos down
      logic wr_item;      // write held entry into pos
      logic out_load;     // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic up_swap;
      logic count_zero;
      logic dn_leaf;
      logic dn_swap;
   } stat_type;

endpackage

// ===== rtl/core/bmhpq_dp.sv =====
// ----------------------------------------------------------------------------
// bmhpq_dp
// Heap memory, held entry, position and count registers, and comparators.
// ----------------------------------------------------------------------------
module bmhpq_dp import bmhpq_pkg::*; #(
   parameter int CAPACITY_ENTRIES = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY_ENTRIES);
   localparam int CNT_W = $clog2(CAPACITY_ENTRIES + 1);
   localparam int EXT_W = IDX_W + 2;

   entry_type            mem [CAPACITY_ENTRIES];
   entry_type            rd_a_ff, rd_b_ff;
   entry_type            item_ff, item_in;
   entry_type            front_ff, front_in;
   entry_type            wr_data, big;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   rsp_type              rsp_ff, rsp_in;
   logic [IDX_W-1:0]     parent, rd_a_addr, rd_b_addr;
   logic [EXT_W-1:0]     left_x, right_x, count_x;
   logic [CNT_W-1:0]     last_x;
   logic                 right_ok, big_right, wr_en;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign parent    = (pos_ff - IDX_W'(1)) >> 1;
   assign left_x    = {1'b0, pos_ff, 1'b1};
   assign right_x   = left_x + EXT_W'(1);
   assign count_x   = EXT_W'(count_ff);
   assign last_x    = count_ff - CNT_W'(1);
   assign right_ok  = right_x < count_x;
   assign big_right = right_ok && (rd_a_ff.prio < rd_b_ff.prio);
   assign big       = big_right ? rd_b_ff : rd_a_ff;

   assign stat.full       = count_ff == CNT_W'(CAPACITY_ENTRIES);
   assign stat.empty      = count_ff == '0;
   assign stat.pos_zero   = pos_ff == '0;
   assign stat.up_swap    = item_ff.prio > rd_a_ff.prio;
   assign stat.count_zero = count_ff == '0;
   assign stat.dn_leaf    = left_x >= count_x;
   assign stat.dn_swap    = item_ff.prio < big.prio;

   // read addresses: root and last entry on remove, parent or children in a sift
   always_comb begin
      rd_a_addr = '0;
      if (cmd.rd_children) begin
         rd_a_addr = left_x[IDX_W-1:0];
      end else if (cmd.rd_parent) begin
         rd_a_addr = parent;
      end
      rd_b_addr = cmd.rd_children ? right_x[IDX_W-1:0] : last_x[IDX_W-1:0];
   end

   always_comb begin
      wr_en   = cmd.up_move || cmd.dn_move || cmd.wr_item;
      wr_data = item_ff;
      if (cmd.up_move) begin
         wr_data = rd_a_ff;
      end else if (cmd.dn_move) begin
         wr_data = big;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_comb begin
      item_in   = item_ff;
      front_in  = front_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.accept) begin
         item_in   = '{data: req_data.entry_data, prio: req_data.entry_priority};
         front_in  = '0;
         status_in = STATUS_DONE;
         if (req_data.mode == MODE_INSERT) begin
            if (stat.full) begin
               status_in = STATUS_FULL;
            end else begin
               pos_in   = count_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (stat.empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.rm_load) begin
         front_in = rd_a_ff;
         item_in  = rd_b_ff;
         pos_in   = '0;
      end
      if (cmd.dn_move) begin
         pos_in = big_right ? right_x[IDX_W-1:0] : left_x[IDX_W-1:0];
      end
   end

   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in.front_data     = front_ff.data;
         rsp_in.front_priority = front_ff.prio;
         rsp_in.status         = status_ff;
         rsp_in.entry_count    = count_wide[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      item_ff   <= item_in;
      front_ff  <= front_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/bmhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Sequencer for insert, remove and the sift loops; owns the result valid.
// ----------------------------------------------------------------------------
module bmhpq_ctrl import bmhpq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_mode,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_UP_RD  = 8'b0000_0010,
      S_UP_CMP = 8'b0000_0100,
      S_RM_LD  = 8'b0000_1000,
      S_DN_RD  = 8'b0001_0000,
      S_DN_CMP = 8'b0010_0000,
      S_DONE   = 8'b0100_0000,
      S_SPARE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_mode == MODE_INSERT) begin
                  state_in = stat.full ? S_DONE : S_UP_RD;
               end else begin
                  state_in = stat.empty ? S_DONE : S_RM_LD;
               end
            end
         end
         S_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.wr_item = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_swap) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.wr_item = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_RM_LD: begin
            cmd.rm_load = 1'b1;
            state_in    = stat.count_zero ? S_DONE : S_DN_RD;
         end
         S_DN_RD: begin
            if (stat.dn_leaf) begin
               cmd.wr_item = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.rd_children = 1'b1;
               state_in        = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (stat.dn_swap) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               cmd.wr_item = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/binary_max_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_top
// Array-based binary max-heap priority queue with insert and remove.
//
//   channel   direction   handshake          payload
//   req       in          req_valid/stall    mode, entry_data, entry_priority
//   rsp       out         rsp_valid/stall    front_data, front_priority,
//                                            status, entry_count
//
// One request at a time. An insert climbs one heap level per parent read and
// compare/write until it reaches the root or stops below; a remove loads the
// root and last entry, then sifts the moved entry down one level per children
// read and compare/write until it settles at a leaf or stops above. A remove
// of the last entry, a dropped insert and an empty remove go straight to the
// result. The sift loops do one registered memory read and one compare/write
// per heap level.
// Synchronous active-high reset empties the heap; the store itself is not
// cleared. A new request is taken while an earlier result waits on a stalled
// rsp channel; the finished result then waits until the result register frees.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_top import bmhpq_pkg::*; #(
   parameter int CAPACITY_ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decides each step of insert, remove and the sifts
   bmhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, held entry, compare logic and result register
   bmhpq_dp #(
      .CAPACITY_ENTRIES (CAPACITY_ENTRIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/heap_check_pkg.sv =====
// ----------------------------------------------------------------------------
// heap_check_pkg
// Tracks a max-heap alongside the queue under test, predicts the response to
// each request and checks what the queue returns.
// ----------------------------------------------------------------------------
package heap_check_pkg;
   import bmhpq_pkg::*;

   localparam int HEAP_SLOTS = 64;

   class heap_order_checker;
      entry_type   slots [HEAP_SLOTS];
      int unsigned held;
      rsp_type     due_rsps [$];
      int          errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         entry_type t;
         t        = slots[a];
         slots[a] = slots[b];
         slots[b] = t;
      endfunction

      // Apply one accepted request to the heap and queue its response.
      function void apply_request(req_type r);
         rsp_type     e;
         int unsigned pos, up, lc, rc, big;
         e = '0;
         if (r.mode == MODE_INSERT) begin
            if (held >= HEAP_SLOTS) begin
               e.status = STATUS_FULL;
            end else begin
               pos        = held;
               slots[pos] = {r.entry_data, r.entry_priority};
               held++;
               while (pos > 0) begin
                  up = (pos - 1) / 2;
                  if (slots[pos].prio <= slots[up].prio) break;
                  swap_slots(pos, up);
                  pos = up;
               end
            end
         end else if (held == 0) begin
            e.status = STATUS_EMPTY;
         end else begin
            e.front_data     = slots[0].data;
            e.front_priority = slots[0].prio;
            held--;
            slots[0] = slots[held];
            pos      = 0;
            // sift down; ties between children go left
            while (2 * pos + 1 < held) begin
               lc  = 2 * pos + 1;
               rc  = lc + 1;
               big = lc;
               if (rc < held && slots[lc].prio < slots[rc].prio) big = rc;
               if (!(slots[pos].prio < slots[big].prio)) break;
               swap_slots(pos, big);
               pos = big;
            end
         end
         e.entry_count = COUNT_W'(held);
         due_rsps.push_back(e);
      endfunction

      function void report_field(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
         end
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_response(rsp_type got);
         rsp_type e;
         if (due_rsps.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected none actual %p",
                     $time, got);
            return;
         end
         e = due_rsps.pop_front();
         report_field("front_data",     e.front_data,     got.front_data);
         report_field("front_priority", e.front_priority, got.front_priority);
         report_field("status",         e.status,         got.status);
         report_field("entry_count",    e.entry_count,    got.entry_count);
      endfunction

      function int outstanding();
         return due_rsps.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and remove requests into the max-heap priority queue with
// random gaps and response stalls, and checks every response against a heap
// kept in step inside the testbench.
// ----------------------------------------------------------------------------
module tb_top;
   import bmhpq_pkg::*;
   import heap_check_pkg::*;

   localparam int RANDOM_REQS = 1950;
   localparam int CYCLE_LIMIT = 400000;
   // one long response hold-off to fill the queue and back up requests
   localparam int HOLD_AT     = 5000;
   localparam int HOLD_LEN    = 400;
   // a window in which the receiver never stalls
   localparam int CALM_AT     = 7000;
   localparam int CALM_LEN    = 3000;
   localparam int DRAIN_WAIT  = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      cycle_count = 0;
   int      rx_cycle    = 0;
   bit      sender_busy = 1'b0;   // set to suppress sender gaps

   heap_order_checker heap_sb = new();

   binary_max_heap_priority_queue_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the queue stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: stall with a chance of about 28 in a hundred, except for one long
   // hold-off and one calm window. Counts its own cycles.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) begin
         rsp_stall <= 1'b1;
      end else if (rx_cycle >= CALM_AT && rx_cycle < CALM_AT + CALM_LEN) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 28);
      end
   end

   // Response monitor: sample at the edge where the response is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) heap_sb.check_response(rsp_data);
   end

   // Offer one request, hold it until the queue takes it, then predict.
   // Valid stays high into the next request unless a gap is drawn.
   task automatic send_request(input req_type r);
      if (!sender_busy) begin
         while ($urandom_range(0, 99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      heap_sb.apply_request(r);
   endtask

   task automatic send_op(input logic mode, input logic [DATA_W-1:0] data,
                          input logic [PRIO_W-1:0] prio);
      req_type r;
      r.mode           = mode;
      r.entry_data     = data;
      r.entry_priority = prio;
      send_request(r);
   endtask

   // Draw a priority: narrow ranges force ties, extremes hit the field limits.
   function automatic logic [PRIO_W-1:0] pick_priority();
      int sel;
      sel = $urandom_range(0, 5);
      case (sel)
         0, 1: begin
            return PRIO_W'($urandom_range(0, 7));
         end
         2: begin
            return ($urandom_range(0, 1) != 0) ? {PRIO_W{1'b1}} : '0;
         end
         default: begin
            return PRIO_W'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   // Insert share for each block of 100 requests: swing between filling the
   // heap past capacity and draining it past empty.
   function automatic int insert_share(int blk);
      case (blk % 5)
         0: return 90;
         1: return 50;
         2: return 10;
         3: return 70;
         default: return 30;
      endcase
   endfunction

   initial begin
      int   n;
      logic m;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: remove from empty with junk payload fields.
      send_op(MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
      // Field extremes, then drain to empty and remove once more.
      send_op(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_op(MODE_INSERT, 32'h0000_0000, 16'h0000);
      send_op(MODE_REMOVE, 32'h0000_0000, 16'h0000);
      send_op(MODE_REMOVE, 32'hA5A5_5A5A, 16'h5A5A);
      send_op(MODE_REMOVE, 32'h0000_0000, 16'h0000);
      // Equal priorities: sift-down must prefer the left child on a tie.
      send_op(MODE_INSERT, 32'h1111_1111, 16'd5);
      send_op(MODE_INSERT, 32'h2222_2222, 16'd5);
      send_op(MODE_INSERT, 32'h3333_3333, 16'd5);
      send_op(MODE_INSERT, 32'h4444_4444, 16'd9);
      send_op(MODE_INSERT, 32'h5555_5555, 16'd5);
      send_op(MODE_INSERT, 32'h6666_6666, 16'h8000);
      send_op(MODE_INSERT, 32'h0000_0000, 16'hFFFF);
      send_op(MODE_INSERT, 32'hFFFF_FFFF, 16'h0000);
      repeat (8) send_op(MODE_REMOVE, 32'h0, 16'h0);

      // Random: blocks alternate between filling and draining the heap.
      for (n = 0; n < RANDOM_REQS; n++) begin
         sender_busy = (n >= 900 && n < 1200);
         m = ($urandom_range(0, 99) < insert_share(n / 100)) ? MODE_INSERT : MODE_REMOVE;
         send_op(m, $urandom, pick_priority());
      end
      sender_busy = 1'b0;
      req_valid <= 1'b0;

      // Drain: wait for every predicted response, then let stragglers show.
      while (heap_sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (heap_sb.errors == 0 && heap_sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
